FILE: sv/psfc_pkg.sv
// Package for the passive serial configuration master: codes, command type, sizes.
package psfc_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_BYTE   = 2'd2;
   localparam logic [1:0] OP_FINISH = 2'd3;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
   localparam logic [2:0] PH_WAIT_HIGH = 3'd2;
   localparam logic [2:0] PH_READY     = 3'd3;
   localparam logic [2:0] PH_DONE      = 3'd4;

   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [3:0] STEP_BYTE_LAST   = 4'd15;
   localparam logic [3:0] STEP_FINISH_HIGH = 4'd1;
   localparam logic [3:0] STEP_FINISH_LAST = 4'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       ncfg;
      logic [2:0] phase;
      logic       err;
   } psfc_cmd_type;

endpackage

FILE: sv/passive_serial_fpga_config.sv
// Top level of the passive serial configuration master.
//
//   channel  direction  tdata                                    tuser / tlast
//   req_     in         [7:0] data_byte [8] nstatus [9] cdone     tuser[1:0] op
//   rsp_     out        [0] nconfig [1] dclk [2] data [5:3] phase tlast = last
//                       [6] error
//
// Tick, start and rejected transactions give one pin word; a data byte gives sixteen,
// one per cycle while the result port is ready; finish gives three. The result port's
// one word per cycle sets the rate. A request is taken every cycle while the command
// queue has room; each result word is registered in the sequencer's output register.
// Reset returns the phase to idle, nCONFIG low and empties the queue.
// A stalled result port backs up through the queue to req_tready.
module passive_serial_fpga_config #(
   parameter int QueueDepth = psfc_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] nstatus_pin, [9] cdone_pin
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] nconfig_out, [1] dclk_out, [2] data_out,
                                    // [5:3] phase, [6] error
   output logic        rsp_tlast
);
   import psfc_pkg::*;

   psfc_cmd_type push_cmd, pop_cmd;
   logic         push_valid, push_ready, pop_valid, pop_ready;

   psfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .op          (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .nstatus_pin (req_tdata[8]),
      .cdone_pin   (req_tdata[9]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   psfc_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   psfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

FILE: sv/psfc_front.sv
// Front end: accepts input transactions, tracks the configuration phase, issues commands.
module psfc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             op,
   input  logic [7:0]             data_byte,
   input  logic                   nstatus_pin,
   input  logic                   cdone_pin,
   output logic                   push_valid,
   input  logic                   push_ready,
   output psfc_pkg::psfc_cmd_type push_cmd
);
   import psfc_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic       ncfg_ff, ncfg_in;
   logic       accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      phase_in      = phase_ff;
      ncfg_in       = ncfg_ff;
      push_cmd.kind = KIND_SINGLE;
      push_cmd.data = data_byte;
      push_cmd.err  = 1'b0;
      case (op)
         OP_TICK: begin
            if (phase_ff == PH_WAIT_LOW && !nstatus_pin && !cdone_pin) begin
               ncfg_in  = 1'b1;
               phase_in = PH_WAIT_HIGH;
            end else if (phase_ff == PH_WAIT_HIGH && nstatus_pin && !cdone_pin) begin
               phase_in = PH_READY;
            end
         end
         OP_START: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_DONE) begin
               ncfg_in  = 1'b0;
               phase_in = PH_WAIT_LOW;
            end else begin
               push_cmd.err = 1'b1;
            end
         end
         OP_BYTE: begin
            if (phase_ff == PH_READY) begin
               push_cmd.kind = KIND_BYTE;
            end else begin
               push_cmd.err = 1'b1;
            end
         end
         default: begin
            if (phase_ff == PH_READY) begin
               push_cmd.kind = KIND_FINISH;
               phase_in      = PH_DONE;
            end else begin
               push_cmd.err = 1'b1;
            end
         end
      endcase
      push_cmd.ncfg  = ncfg_in;
      push_cmd.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ncfg_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ncfg_ff  <= ncfg_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_ncfg_high_phase: assert property (@(posedge clock) disable iff (reset)
      ncfg_ff |-> (phase_ff == PH_WAIT_HIGH || phase_ff == PH_READY
                   || phase_ff == PH_DONE))
      else $error("nCONFIG high outside post-reset phases");
   a_err_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && push_cmd.err) |=> ($stable(phase_ff) && $stable(ncfg_ff)))
      else $error("error transaction changed state");
   a_done_from_ready: assert property (@(posedge clock) disable iff (reset)
      ($past(phase_ff) != PH_DONE && phase_ff == PH_DONE)
      |-> $past(phase_ff) == PH_READY)
      else $error("done phase not entered from ready");
`endif
endmodule

FILE: sv/psfc_queue.sv
// Command queue between front end and pin sequencer.
module psfc_queue #(
   parameter int Depth = psfc_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  psfc_pkg::psfc_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output psfc_pkg::psfc_cmd_type pop_cmd
);
   import psfc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   psfc_cmd_type    slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CntW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count overflow");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with unequal pointers");
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CntW'(Depth)) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("full queue with unequal pointers");
`endif
endmodule

FILE: sv/psfc_back.sv
// Pin sequencer: expands commands into pin words and holds the output register.
module psfc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  psfc_pkg::psfc_cmd_type pop_cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import psfc_pkg::*;

   logic         active_ff, active_in;
   psfc_cmd_type cmd_ff, cur_cmd;
   logic [3:0]   step_ff, cur_step;
   logic         valid_ff, valid_in;
   logic [6:0]   word_ff, word_in;
   logic         last_ff, last_in;
   logic         adv, cur_valid, fire;
   logic         clk_bit, dat_bit;

   assign adv       = !valid_ff || rsp_tready;
   assign cur_valid = active_ff || pop_valid;
   assign cur_cmd   = active_ff ? cmd_ff : pop_cmd;
   assign cur_step  = active_ff ? step_ff : 4'd0;
   assign fire      = adv && cur_valid;
   assign pop_ready = adv && !active_ff;

   always_comb begin
      clk_bit = 1'b0;
      dat_bit = 1'b0;
      last_in = 1'b1;
      case (cur_cmd.kind)
         KIND_BYTE: begin
            clk_bit = cur_step[0];
            dat_bit = cur_cmd.data[cur_step[3:1]];
            last_in = cur_step == STEP_BYTE_LAST;
         end
         KIND_FINISH: begin
            clk_bit = cur_step == STEP_FINISH_HIGH;
            last_in = cur_step == STEP_FINISH_LAST;
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
      word_in   = {cur_cmd.err, cur_cmd.phase, dat_bit, clk_bit, cur_cmd.ncfg};
      valid_in  = adv ? cur_valid : valid_ff;
      active_in = fire ? !last_in : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff <= word_in;
         last_ff <= last_in;
         cmd_ff  <= cur_cmd;
         step_ff <= cur_step + 4'd1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, word_ff};
   assign rsp_tlast  = last_ff;

`ifndef NO_ASSERTIONS
   a_active_has_word: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> valid_ff)
      else $error("sequencer active without pending word");
   a_active_kind: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cmd_ff.kind == KIND_BYTE || cmd_ff.kind == KIND_FINISH))
      else $error("single-word command left sequencer active");
   a_finish_steps: assert property (@(posedge clock) disable iff (reset)
      (active_ff && cmd_ff.kind == KIND_FINISH) |-> step_ff <= STEP_FINISH_LAST)
      else $error("finish pulse ran too long");
   a_active_not_last: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !last_ff)
      else $error("word marked last while command still running");
`endif
endmodule
